[hw/rtl/lcc_pkg.sv]
// Shared types, constants and generator tables for the LTE CRC checker.
package lcc_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int COUNT_W       = 6;
  localparam int REM_W         = 24;
  localparam int MASK_W        = 16;
  localparam int ADDR_W        = 4;
  localparam int DATA_W        = 32;
  localparam int SHIFT_W       = 5;

  typedef enum logic [1:0] {
    CRC_8   = 2'd0,
    CRC_16  = 2'd1,
    CRC_24A = 2'd2,
    CRC_24B = 2'd3
  } lcc_crc_type_t;

  typedef enum logic [1:0] {
    REG_CRC_TYPE = 2'd0,
    REG_SCRAMBLE = 2'd1,
    REG_MASK     = 2'd2
  } lcc_reg_t;

  typedef struct packed {
    lcc_crc_type_t     crc_type;
    logic              scramble_enable;
    logic [MASK_W-1:0] crc_mask;
  } lcc_cfg_t;

  typedef struct packed {
    logic             crc_ok;
    logic [REM_W-1:0] remainder;
  } lcc_result_t;

  // Generator polynomial without its x^n term, moved up so its x^(n-1) term sits at bit REM_W-1.
  function automatic logic [REM_W-1:0] poly_aligned(lcc_crc_type_t sel);
    logic [REM_W-1:0] p;
    case (sel)
      CRC_8:   p = 24'h9B0000;
      CRC_16:  p = 24'h102100;
      CRC_24A: p = 24'h864CFB;
      CRC_24B: p = 24'h800063;
      default: p = 24'h864CFB;
    endcase
    return p;
  endfunction

  function automatic logic [SHIFT_W-1:0] align_shift(lcc_crc_type_t sel);
    logic [SHIFT_W-1:0] s;
    case (sel)
      CRC_8:   s = 5'd16;
      CRC_16:  s = 5'd8;
      CRC_24A: s = 5'd0;
      CRC_24B: s = 5'd0;
      default: s = 5'd0;
    endcase
    return s;
  endfunction

  function automatic logic [REM_W-1:0] width_mask(lcc_crc_type_t sel);
    logic [REM_W-1:0] m;
    case (sel)
      CRC_8:   m = 24'h0000FF;
      CRC_16:  m = 24'h00FFFF;
      CRC_24A: m = 24'hFFFFFF;
      CRC_24B: m = 24'hFFFFFF;
      default: m = 24'hFFFFFF;
    endcase
    return m;
  endfunction

endpackage

[hw/rtl/lcc_apb_regs.sv]
// APB configuration registers: generator select, scramble enable, PBCH mask.
module lcc_apb_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcc_pkg::DATA_W-1:0]  pwdata,
  output logic [lcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  output lcc_pkg::lcc_cfg_t           cfg
);

  lcc_pkg::lcc_cfg_t cfg_q;
  lcc_pkg::lcc_reg_t reg_sel;
  logic              wr_en;

  assign pready  = 1'b1;
  assign reg_sel = lcc_pkg::lcc_reg_t'(paddr[3:2]);
  assign wr_en   = psel && penable && pwrite && pready;
  assign cfg     = cfg_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_q.crc_type        <= lcc_pkg::CRC_8;
      cfg_q.scramble_enable <= 1'b0;
      cfg_q.crc_mask        <= '0;
    end else if (wr_en) begin
      case (reg_sel)
        lcc_pkg::REG_CRC_TYPE: cfg_q.crc_type <= lcc_pkg::lcc_crc_type_t'(pwdata[1:0]);
        lcc_pkg::REG_SCRAMBLE: cfg_q.scramble_enable <= pwdata[0];
        lcc_pkg::REG_MASK:     cfg_q.crc_mask <= pwdata[lcc_pkg::MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_sel)
      lcc_pkg::REG_CRC_TYPE: prdata[1:0] = cfg_q.crc_type;
      lcc_pkg::REG_SCRAMBLE: prdata[0] = cfg_q.scramble_enable;
      lcc_pkg::REG_MASK:     prdata[lcc_pkg::MASK_W-1:0] = cfg_q.crc_mask;
      default:               prdata = '0;
    endcase
  end

endmodule

[hw/rtl/lcc_crc_datapath.sv]
// Input register, running remainder and combinational parallel CRC update.
module lcc_crc_datapath #(
  parameter int WORD_BITS = lcc_pkg::WORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  lcc_pkg::lcc_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [WORD_BITS-1:0]         data_word,
  input  logic [lcc_pkg::COUNT_W-1:0]  bit_count,
  input  logic                         last_word,
  output logic                         res_valid,
  output lcc_pkg::lcc_result_t         res,
  input  logic                         res_ready
);

  localparam int CNT_EXT_W = lcc_pkg::COUNT_W + 1;
  localparam logic [CNT_EXT_W-1:0] WORD_BITS_CNT = CNT_EXT_W'(WORD_BITS);

  logic                         held;
  logic [WORD_BITS-1:0]         word_q;
  logic [lcc_pkg::COUNT_W-1:0]  count_q;
  logic                         last_q;
  logic [lcc_pkg::REM_W-1:0]    rem;

  logic                         fire;
  logic                         accept;
  logic [CNT_EXT_W-1:0]         count_ext;
  logic [CNT_EXT_W-1:0]         count_sat;
  logic [lcc_pkg::REM_W-1:0]    acc;
  logic [lcc_pkg::REM_W-1:0]    poly;
  logic [lcc_pkg::SHIFT_W-1:0]  sh;
  logic [lcc_pkg::REM_W-1:0]    rem_next;
  logic [lcc_pkg::REM_W-1:0]    expected;
  logic                         fb;

  assign fire     = held && (!last_q || res_ready);
  assign in_stall = held && !fire;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
      rem  <= '0;
    end else begin
      if (accept) begin
        held <= 1'b1;
      end else if (fire) begin
        held <= 1'b0;
      end
      if (fire) begin
        rem <= last_q ? '0 : rem_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      word_q  <= data_word;
      count_q <= bit_count;
      last_q  <= last_word;
    end
  end

  always_comb begin
    count_ext = {1'b0, count_q};
    count_sat = (count_ext > WORD_BITS_CNT) ? WORD_BITS_CNT : count_ext;
    poly      = lcc_pkg::poly_aligned(cfg.crc_type);
    sh        = lcc_pkg::align_shift(cfg.crc_type);
    acc       = (rem & lcc_pkg::width_mask(cfg.crc_type)) << sh;
    fb        = 1'b0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (CNT_EXT_W'(i) < count_sat) begin
        fb  = word_q[WORD_BITS-1-i] ^ acc[lcc_pkg::REM_W-1];
        acc = {acc[lcc_pkg::REM_W-2:0], 1'b0} ^ (fb ? poly : '0);
      end
    end
    rem_next = acc >> sh;
    expected = cfg.scramble_enable
             ? {{(lcc_pkg::REM_W-lcc_pkg::MASK_W){1'b0}}, cfg.crc_mask} : '0;
  end

  assign res_valid     = fire && last_q;
  assign res.crc_ok    = (rem_next == expected);
  assign res.remainder = rem_next;

endmodule

[hw/rtl/lcc_result_reg.sv]
// Output register for check results, held while the receiver stalls.
module lcc_result_reg (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        res_valid,
  input  lcc_pkg::lcc_result_t        res,
  output logic                        res_ready,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        crc_ok,
  output logic [lcc_pkg::REM_W-1:0]   remainder
);

  lcc_pkg::lcc_result_t res_q;

  assign res_ready = !out_valid || !out_stall;
  assign crc_ok    = res_q.crc_ok;
  assign remainder = res_q.remainder;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

endmodule

[hw/rtl/lte_crc_checker_unit.sv]
// Top level of the LTE code block CRC checker (CRC8, CRC16, CRC24A, CRC24B).
//
// Input channel: data_word carries received bits, first bit in the MSB, with
// bit_count valid bits taken from the top (counts above the word width are
// treated as a full word) and last_word marking the final word of a block.
// A request is taken when in_valid is high and in_stall is low.
// Output channel: one result per block, on its last word: crc_ok and the
// right-aligned remainder. A request is taken when out_valid is high and
// out_stall is low.
// The result of a last word is computed from the input register and captured in the result register.
// Throughput: one word per cycle while in_stall is low; the remainder update
// over a full word is a combinational parallel XOR network fed back into the
// remainder register. When the receiver stalls, the result register holds, the
// input register holds the next last word, and in_stall rises; non-last words
// keep flowing while the result register is full.
// Reset clears the remainder, both valid flags and the configuration
// registers. Configure over APB only while no block is in flight.
module lte_crc_checker_unit #(
  parameter int WORD_BITS = lcc_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [lcc_pkg::ADDR_W-1:0]  paddr,
  input  logic [lcc_pkg::DATA_W-1:0]  pwdata,
  output logic [lcc_pkg::DATA_W-1:0]  prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [WORD_BITS-1:0]        data_word,
  input  logic [lcc_pkg::COUNT_W-1:0] bit_count,
  input  logic                        last_word,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        crc_ok,
  output logic [lcc_pkg::REM_W-1:0]   remainder
);

  lcc_pkg::lcc_cfg_t    cfg;
  lcc_pkg::lcc_result_t res;
  logic                 res_valid;
  logic                 res_ready;

  lcc_apb_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  lcc_crc_datapath #(
    .WORD_BITS (WORD_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .data_word (data_word),
    .bit_count (bit_count),
    .last_word (last_word),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready)
  );

  lcc_result_reg u_result (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .crc_ok    (crc_ok),
    .remainder (remainder)
  );

endmodule
